// ===== rtl/core/battery_soc_runtime_estimator_assert.svh =====
// Assertion macros shared by the estimator RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BATTERY_SOC_RUNTIME_ESTIMATOR_ASSERT_SVH
`define BATTERY_SOC_RUNTIME_ESTIMATOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BSE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bse: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define BSE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bse: implication violated");

`endif

// ===== rtl/core/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Types, constants and curve tables for the state-of-charge and runtime
// estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

  // Field widths.
  localparam int unsigned VOLT_W = 15;
  localparam int unsigned CUR_W  = 18;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned SOC_W  = 14;
  localparam int unsigned CAP_W  = 20;
  localparam int unsigned RT_W   = 24;
  localparam int unsigned Q_W    = CAP_W + SOC_W;   // capacity times charge
  localparam int unsigned D_W    = 24;              // 100 times current
  localparam int unsigned DSH_W  = D_W + RT_W - 1;  // divisor aligned to top bit
  localparam int unsigned N_W    = 13;              // interpolation numerator
  localparam int unsigned OFS_W  = 11;              // offset inside a segment
  localparam int unsigned NUM_W  = 5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_CHEMISTRY  = 2'd1,
    CFG_CONFIGURED = 2'd2
  } cfg_idx_t;

  localparam logic CHEM_LFP  = 1'b0;
  localparam logic CHEM_LEAD = 1'b1;

  localparam logic [SOC_W-1:0] LEAD_RESERVE_BP = 14'd5000;
  localparam logic [6:0]       CENTI_SCALE     = 7'd100;
  // Reciprocal of three scaled by two to the fifteenth; exact for N_W bits.
  localparam logic [13:0]      RECIP3          = 14'd10923;

  // Segment slopes reduce to a small numerator over 1, 2, 3 or 4.
  typedef enum logic [1:0] {
    DEN_1,
    DEN_2,
    DEN_3,
    DEN_4
  } den_t;

  typedef struct packed {
    logic [VOLT_W-1:0] v0;
    logic [SOC_W-1:0]  s0;
    logic [NUM_W-1:0]  num;
    den_t              den;
  } seg_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             chemistry;
    logic             configured;
  } bse_cfg_t;

  // Payload that travels along the divider cells.
  typedef struct packed {
    logic [SOC_W-1:0] soc;
    logic             rv;
    logic             sat;
    logic [Q_W-1:0]   rem;
    logic [DSH_W-1:0] dsh;
    logic [RT_W-1:0]  quot;
  } bse_div_t;

  // Lithium iron phosphate curve.
  localparam int unsigned LFP_PTS = 11;
  localparam logic [VOLT_W-1:0] LFP_MV [LFP_PTS] = '{
    15'd10000, 15'd12000, 15'd12500, 15'd12800, 15'd12900, 15'd13000,
    15'd13100, 15'd13200, 15'd13300, 15'd13400, 15'd13600};
  localparam logic [SOC_W-1:0] LFP_BP [LFP_PTS] = '{
    14'd0, 14'd500, 14'd1000, 14'd1700, 14'd2500, 14'd3500,
    14'd5500, 14'd7500, 14'd9000, 14'd9500, 14'd10000};
  localparam logic [NUM_W-1:0] LFP_NUM [LFP_PTS-1] = '{
    5'd1, 5'd1, 5'd7, 5'd8, 5'd10, 5'd20, 5'd20, 5'd15, 5'd5, 5'd5};
  localparam den_t LFP_DEN [LFP_PTS-1] = '{
    DEN_4, DEN_1, DEN_3, DEN_1, DEN_1, DEN_1, DEN_1, DEN_1, DEN_1, DEN_2};

  // Lead-acid curve.
  localparam int unsigned PB_PTS = 5;
  localparam logic [VOLT_W-1:0] PB_MV [PB_PTS] = '{
    15'd10500, 15'd12000, 15'd12200, 15'd12400, 15'd12700};
  localparam logic [SOC_W-1:0] PB_BP [PB_PTS] = '{
    14'd0, 14'd2500, 14'd5000, 14'd7500, 14'd10000};
  localparam logic [NUM_W-1:0] PB_NUM [PB_PTS-1] = '{
    5'd5, 5'd25, 5'd25, 5'd25};
  localparam den_t PB_DEN [PB_PTS-1] = '{
    DEN_3, DEN_2, DEN_2, DEN_3};

  // Picks the segment of the selected curve that holds the voltage. Outside
  // the curve a flat segment with the end value is returned.
  function automatic seg_t seg_lookup(input logic chem, input logic [VOLT_W-1:0] v);
    seg_t seg;
    seg = '{v0: v, s0: '0, num: '0, den: DEN_1};
    if (chem == CHEM_LFP) begin
      if (v >= LFP_MV[LFP_PTS-1]) begin
        seg.s0 = LFP_BP[LFP_PTS-1];
      end
      for (int i = 0; i < LFP_PTS - 1; i++) begin
        if (v >= LFP_MV[i] && v < LFP_MV[i+1]) begin
          seg = '{v0: LFP_MV[i], s0: LFP_BP[i], num: LFP_NUM[i], den: LFP_DEN[i]};
        end
      end
    end else begin
      if (v >= PB_MV[PB_PTS-1]) begin
        seg.s0 = PB_BP[PB_PTS-1];
      end
      for (int i = 0; i < PB_PTS - 1; i++) begin
        if (v >= PB_MV[i] && v < PB_MV[i+1]) begin
          seg = '{v0: PB_MV[i], s0: PB_BP[i], num: PB_NUM[i], den: PB_DEN[i]};
        end
      end
    end
    return seg;
  endfunction

  // Divides the interpolation numerator by the segment's small denominator.
  function automatic logic [N_W-1:0] div_den(input logic [N_W-1:0] n, input den_t den);
    logic [N_W+14:0] prod;
    logic [N_W-1:0]  res;
    prod = (N_W + 15)'(n) * (N_W + 15)'(RECIP3);
    unique case (den)
      DEN_1:   res = n;
      DEN_2:   res = n >> 1;
      DEN_3:   res = prod[N_W+14:15];
      DEN_4:   res = n >> 2;
      default: res = n;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/bse_front.sv =====
// ----------------------------------------------------------------------------
// bse_front
// Four-stage front end: curve lookup, interpolation, charge and divisor
// products, and set-up of the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_soc_runtime_estimator_assert.svh"

module bse_front
  import bse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  bse_cfg_t                 cfg,
  input  logic                     up_valid,
  output logic                     up_stall,
  input  logic [VOLT_W-1:0]        voltage_mv,
  input  logic signed [CUR_W-1:0]  current_ma,
  output logic                     dn_valid,
  input  logic                     dn_stall,
  output bse_div_t                 dn_data
);

  logic stall1, stall2, stall3, stall4;
  logic v1, v2, v3, v4;

  // Stage 1 registers.
  logic [N_W-1:0]   s1_n;
  logic [SOC_W-1:0] s1_s0;
  den_t             s1_den;
  logic             s1_rv;
  logic             s1_chem;
  logic [MAG_W-1:0] s1_cur;

  // Stage 2 registers.
  logic [SOC_W-1:0] s2_soc;
  logic [SOC_W-1:0] s2_eff;
  logic             s2_rv;
  logic [MAG_W-1:0] s2_cur;

  // Stage 3 registers.
  logic [SOC_W-1:0] s3_soc;
  logic             s3_rv;
  logic [Q_W-1:0]   s3_q;
  logic [D_W-1:0]   s3_d;

  seg_t             seg;
  logic [OFS_W-1:0] ofs;
  logic             positive;
  logic [SOC_W-1:0] soc_c;

  // A stage holds when it is full and the stage after it holds.
  assign stall4   = v4 & dn_stall;
  assign stall3   = v3 & stall4;
  assign stall2   = v2 & stall3;
  assign stall1   = v1 & stall2;
  assign up_stall = stall1;
  assign dn_valid = v4;

  // Segment selection and the offset inside it.
  assign seg      = seg_lookup(cfg.chemistry, voltage_mv);
  assign ofs      = OFS_W'(voltage_mv - seg.v0);
  assign positive = !current_ma[CUR_W-1] && (current_ma != '0);

  // Interpolated charge.
  assign soc_c = s1_s0 + div_den(s1_n, s1_den);

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!stall1) v1 <= up_valid;
      if (!stall2) v2 <= v1;
      if (!stall3) v3 <= v2;
      if (!stall4) v4 <= v3;
    end
  end

  // Stage 1: segment parameters and the slope product.
  always_ff @(posedge clk) begin
    if (up_valid && !stall1) begin
      s1_n    <= N_W'(seg.num) * N_W'(ofs);
      s1_s0   <= seg.s0;
      s1_den  <= seg.den;
      s1_rv   <= cfg.configured & positive;
      s1_chem <= cfg.chemistry;
      s1_cur  <= current_ma[MAG_W-1:0];
    end
  end

  // Stage 2: charge and the part of it above the lead-acid reserve.
  always_ff @(posedge clk) begin
    if (v1 && !stall2) begin
      s2_soc <= soc_c;
      if (s1_chem == CHEM_LEAD) begin
        s2_eff <= (soc_c > LEAD_RESERVE_BP) ? soc_c - LEAD_RESERVE_BP : '0;
      end else begin
        s2_eff <= soc_c;
      end
      s2_rv  <= s1_rv;
      s2_cur <= s1_cur;
    end
  end

  // Stage 3: remaining charge and the scaled divisor.
  always_ff @(posedge clk) begin
    if (v2 && !stall3) begin
      s3_soc <= s2_soc;
      s3_rv  <= s2_rv;
      s3_q   <= Q_W'(cfg.capacity) * Q_W'(s2_eff);
      s3_d   <= D_W'(s2_cur) * D_W'(CENTI_SCALE);
    end
  end

  // Stage 4: saturation check and the divider's starting point.
  always_ff @(posedge clk) begin
    if (v3 && !stall4) begin
      dn_data.soc  <= s3_soc;
      dn_data.rv   <= s3_rv;
      dn_data.sat  <= {(D_W + RT_W - Q_W)'(0), s3_q} >= {s3_d, RT_W'(0)};
      dn_data.rem  <= s3_q;
      dn_data.dsh  <= {s3_d, (RT_W - 1)'(0)};
      dn_data.quot <= '0;
    end
  end

  `BSE_ASSERT_IMPLY(a_divisor_nonzero, v3 && s3_rv, s3_d != '0)
  `BSE_ASSERT_IMPLY(a_soc_stage_range, v2, s2_soc <= LFP_BP[LFP_PTS-1])

endmodule

// ===== rtl/core/bse_div_cell.sv =====
// ----------------------------------------------------------------------------
// bse_div_cell
// One cell of the restoring divider chain: settles one quotient bit and hands
// the remainder and the halved divisor to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_soc_runtime_estimator_assert.svh"

module bse_div_cell
  import bse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  bse_div_t up_data,
  output logic     dn_valid,
  input  logic     dn_stall,
  output bse_div_t dn_data
);

  logic vld;
  logic ge;

  assign up_stall = vld & dn_stall;
  assign dn_valid = vld;

  // Trial subtraction of the aligned divisor.
  assign ge = {(DSH_W - Q_W)'(0), up_data.rem} >= up_data.dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!up_stall) begin
      vld <= up_valid;
    end
  end

  // Payload moves on whenever the cell is free.
  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      dn_data.soc  <= up_data.soc;
      dn_data.rv   <= up_data.rv;
      dn_data.sat  <= up_data.sat;
      dn_data.rem  <= ge ? up_data.rem - Q_W'(up_data.dsh) : up_data.rem;
      dn_data.dsh  <= up_data.dsh >> 1;
      dn_data.quot <= {up_data.quot[RT_W-2:0], ge};
    end
  end

  // Without saturation the remainder stays below the divisor just used.
  `BSE_ASSERT_IMPLY(a_rem_bound, vld && dn_data.rv && !dn_data.sat,
    {(DSH_W + 1 - Q_W)'(0), dn_data.rem} < {dn_data.dsh, 1'b0})

endmodule

// ===== rtl/core/battery_soc_runtime_estimator.sv =====
// ----------------------------------------------------------------------------
// battery_soc_runtime_estimator: an input transfer passes the four front stages, then
// the 24-cell divider chain, to the result. Throughput one item per cycle while the output
// is not stalled; each stage holds one item and empty slots close up under output stall.
// Synchronous reset empties the pipeline and clears all configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_soc_runtime_estimator_assert.svh"

module battery_soc_runtime_estimator
  import bse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [CAP_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VOLT_W-1:0]        voltage_mv,
  input  logic signed [CUR_W-1:0]  current_ma,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SOC_W-1:0]         soc_bp,
  output logic [RT_W-1:0]          runtime_centihours,
  output logic                     runtime_valid
);

  bse_cfg_t cfg;
  logic     div_vld   [RT_W+1];
  logic     div_stall [RT_W+1];
  bse_div_t div_data  [RT_W+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CAPACITY:   cfg.capacity   <= cfg_data;
        CFG_CHEMISTRY:  cfg.chemistry  <= cfg_data[0];
        CFG_CONFIGURED: cfg.configured <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Lookup, interpolation and divider set-up.
  bse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .voltage_mv (voltage_mv),
    .current_ma (current_ma),
    .dn_valid   (div_vld[0]),
    .dn_stall   (div_stall[0]),
    .dn_data    (div_data[0])
  );

  // Divider chain, one quotient bit per cell, most significant first.
  for (genvar k = 0; k < RT_W; k++) begin : g_cell
    bse_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_vld[k]),
      .up_stall (div_stall[k]),
      .up_data  (div_data[k]),
      .dn_valid (div_vld[k+1]),
      .dn_stall (div_stall[k+1]),
      .dn_data  (div_data[k+1])
    );
  end

  // Result from the last cell.
  assign div_stall[RT_W]   = out_stall;
  assign out_valid         = div_vld[RT_W];
  assign soc_bp            = div_data[RT_W].soc;
  assign runtime_valid     = div_data[RT_W].rv;
  assign runtime_centihours = !div_data[RT_W].rv ? '0 :
                              div_data[RT_W].sat ? '1 : div_data[RT_W].quot;

  `BSE_ASSERT_IMPLY(a_soc_range, out_valid, soc_bp <= LFP_BP[LFP_PTS-1])
  `BSE_ASSERT_IMPLY(a_stall_chain, in_stall, out_valid && out_stall)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: state-of-charge and runtime estimator bench
// A directed table of samples and register writes runs first. Seeded random
// phases follow, each under its own capacity and chemistry setting. Every
// result transfer is checked field by field against the row's written expectation or an
// in-bench calculation of the voltage curve and the runtime division. Both handshake
// sides idle at random, and one long output hold-off forces the pipeline to fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bse_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 66;
  localparam int ROWS          = 25;
  localparam logic [RT_W-1:0] RT_CEIL = 24'hFFFFFF;

  // Curve breakpoints in millivolts and basis points.
  localparam int FE_MV [11] = '{10000, 12000, 12500, 12800, 12900, 13000,
                                13100, 13200, 13300, 13400, 13600};
  localparam int FE_BP [11] = '{0, 500, 1000, 1700, 2500, 3500,
                                5500, 7500, 9000, 9500, 10000};
  localparam int ACID_MV [5] = '{10500, 12000, 12200, 12400, 12700};
  localparam int ACID_BP [5] = '{0, 2500, 5000, 7500, 10000};

  typedef struct {
    logic [SOC_W-1:0] soc;
    logic [RT_W-1:0]  rt;
    logic             rv;
  } estimate_t;

  // One line of the directed plan: either a register write or a sample.
  typedef struct {
    bit                       is_write;
    cfg_idx_t                 idx;
    logic [CAP_W-1:0]         data;
    logic [VOLT_W-1:0]        volt;
    logic signed [CUR_W-1:0]  cur;
    bit                       known;
    estimate_t                want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [CAP_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [VOLT_W-1:0]       voltage_mv = '0;
  logic signed [CUR_W-1:0] current_ma = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [SOC_W-1:0]        soc_bp;
  logic [RT_W-1:0]         runtime_centihours;
  logic                    runtime_valid;

  // Register copies that the calculation uses.
  logic [CAP_W-1:0] model_cap = '0;
  logic             model_chem = CHEM_LFP;
  logic             model_cfgd = 1'b0;

  estimate_t   awaited_results [$];
  plan_row_t   plan [ROWS];
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        calm = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  battery_soc_runtime_estimator i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .voltage_mv         (voltage_mv),
    .current_ma         (current_ma),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .soc_bp             (soc_bp),
    .runtime_centihours (runtime_centihours),
    .runtime_valid      (runtime_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Piecewise-linear voltage curve, clamped at both ends, truncating.
  function automatic logic [SOC_W-1:0] soc_from_voltage(logic chem, logic [VOLT_W-1:0] v);
    int mv [11];
    int bp [11];
    int n;
    int vi;
    vi = v;
    if (chem == CHEM_LFP) begin
      n = 11;
      for (int i = 0; i < 11; i++) begin
        mv[i] = FE_MV[i];
        bp[i] = FE_BP[i];
      end
    end else begin
      n = 5;
      for (int i = 0; i < 5; i++) begin
        mv[i] = ACID_MV[i];
        bp[i] = ACID_BP[i];
      end
    end
    if (vi < mv[0]) return SOC_W'(bp[0]);
    if (vi >= mv[n-1]) return SOC_W'(bp[n-1]);
    for (int i = 0; i < n - 1; i++) begin
      if (vi >= mv[i] && vi < mv[i+1]) begin
        return SOC_W'(bp[i] + ((bp[i+1] - bp[i]) * (vi - mv[i])) / (mv[i+1] - mv[i]));
      end
    end
    return SOC_W'(bp[n-1]);
  endfunction

  // Charge left over the current draw, with the lead-acid reserve held back.
  function automatic estimate_t estimate_runtime(logic [VOLT_W-1:0] v,
                                                 logic signed [CUR_W-1:0] c);
    estimate_t        e;
    longint unsigned  usable;
    longint unsigned  charge;
    longint unsigned  quot;
    int               ci;
    ci = c;
    e.soc = soc_from_voltage(model_chem, v);
    e.rt = '0;
    e.rv = 1'b0;
    if (model_cfgd && ci > 0) begin
      usable = e.soc;
      if (model_chem == CHEM_LEAD) begin
        usable = (e.soc > LEAD_RESERVE_BP) ? longint'(e.soc - LEAD_RESERVE_BP) : 0;
      end
      charge = longint'(model_cap) * usable;
      quot = charge / (longint'(ci) * 100);
      e.rt = (quot > RT_CEIL) ? RT_CEIL : RT_W'(quot);
      e.rv = 1'b1;
    end
    return e;
  endfunction

  function automatic plan_row_t row_write(cfg_idx_t idx, logic [CAP_W-1:0] data);
    plan_row_t r;
    r = '{default: '0, idx: idx, want: '{default: '0}};
    r.is_write = 1'b1;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t row_item(logic [VOLT_W-1:0] v, logic signed [CUR_W-1:0] c);
    plan_row_t r;
    r = '{default: '0, idx: CFG_CAPACITY, want: '{default: '0}};
    r.volt = v;
    r.cur = c;
    return r;
  endfunction

  function automatic plan_row_t row_known(logic [VOLT_W-1:0] v, logic signed [CUR_W-1:0] c,
                                          int soc, int rt, bit rv);
    plan_row_t r;
    r = row_item(v, c);
    r.known = 1'b1;
    r.want = '{soc: SOC_W'(soc), rt: RT_W'(rt), rv: rv};
    return r;
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one sample until it is taken, then records what should come back.
  task automatic send_sample(logic [VOLT_W-1:0] v, logic signed [CUR_W-1:0] c,
                             bit known, estimate_t want);
    int gap;
    in_valid <= 1'b1;
    voltage_mv <= v;
    current_ma <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known) awaited_results.push_back(want);
    else awaited_results.push_back(estimate_runtime(v, c));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_register(cfg_idx_t idx, logic [CAP_W-1:0] data);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_CAPACITY:   model_cap = data;
      CFG_CHEMISTRY:  model_chem = data[0];
      CFG_CONFIGURED: model_cfgd = data[0];
      default: ;
    endcase
    cfg_write <= 1'b0;
  endtask

  // Random voltage: mostly across the curves, some near a breakpoint, some anywhere.
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int r;
    int knee;
    r = $urandom_range(0, 9);
    if (r < 6) return VOLT_W'($urandom_range(9800, 13800));
    if (r < 8) return VOLT_W'($urandom);
    if (model_chem == CHEM_LFP) knee = FE_MV[$urandom_range(0, 10)];
    else knee = ACID_MV[$urandom_range(0, 4)];
    return VOLT_W'(knee + $urandom_range(0, 2) - 1);
  endfunction

  // Random current: mostly moderate draws, plus saturation, zero and negative.
  function automatic logic signed [CUR_W-1:0] pick_current();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CUR_W'($urandom_range(1, 3000));
    if (r < 6) return CUR_W'($urandom_range(1, 8));
    if (r < 7) return '0;
    if (r < 8) return -CUR_W'($urandom_range(1, 131072));
    if (r < 9) return CUR_W'($urandom);
    return CUR_W'($urandom_range(100000, 131071));
  endfunction

  // Output stall: random runs, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (calm || r < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: soc_bp %0d", soc_bp);
        mismatches++;
      end else begin
        e = awaited_results.pop_front();
        if (soc_bp !== e.soc) begin
          $error("soc_bp: expected %0d, got %0d", e.soc, soc_bp);
          mismatches++;
        end
        if (runtime_centihours !== e.rt) begin
          $error("runtime_centihours: expected %0d, got %0d", e.rt, runtime_centihours);
          mismatches++;
        end
        if (runtime_valid !== e.rv) begin
          $error("runtime_valid: expected %0d, got %0d", e.rv, runtime_valid);
          mismatches++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap;
    logic             chem;
    logic             cfgd;

    // Directed plan: ends of the curves, current signs, saturation and reserve.
    plan = '{
      row_known(15'd0, 18'sd0, 0, 0, 1'b0),
      row_known(15'd32767, 18'sd131071, 10000, 0, 1'b0),
      row_write(CFG_CAPACITY, 20'hFFFFF),
      row_write(CFG_CONFIGURED, 20'd1),
      row_known(15'd13600, 18'sd1, 10000, 16777215, 1'b1),
      row_known(15'd9999, 18'sd131071, 0, 0, 1'b1),
      row_known(15'd13000, -18'sd131072, 3500, 0, 1'b0),
      row_known(15'd12500, 18'sd0, 1000, 0, 1'b0),
      row_item(15'd12001, 18'sd500),
      row_item(15'd12799, 18'sd1000),
      row_item(15'd13599, 18'sd1234),
      row_item(15'd10000, 18'sd2),
      row_item(15'd13100, 18'sd7),
      row_write(CFG_CHEMISTRY, 20'd1),
      row_known(15'd12700, 18'sd100, 10000, 524287, 1'b1),
      row_known(15'd12200, 18'sd100, 5000, 0, 1'b1),
      row_known(15'd10499, 18'sd5, 0, 0, 1'b1),
      row_item(15'd12050, 18'sd3),
      row_item(15'd12699, 18'sd77),
      row_item(15'd11999, 18'sd131071),
      row_item(15'd12399, 18'sd10),
      row_write(CFG_CAPACITY, 20'd0),
      row_known(15'd12700, 18'sd50, 10000, 0, 1'b1),
      row_write(CFG_CONFIGURED, 20'd0),
      row_known(15'd12400, 18'sd50, 7500, 0, 1'b0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) write_register(plan[i].idx, plan[i].data);
      else send_sample(plan[i].volt, plan[i].cur, plan[i].known, plan[i].want);
    end

    // Random phases, each under a fresh register setting.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) cap = 20'hFFFFF;
      else if (p == 1) cap = '0;
      else if (p == 2) cap = 20'd1;
      else cap = CAP_W'($urandom);
      chem = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      cfgd = (p == 3) ? 1'b0 : 1'b1;
      write_register(CFG_CAPACITY, cap);
      write_register(CFG_CHEMISTRY, {{(CAP_W-1){1'b0}}, chem});
      write_register(CFG_CONFIGURED, {{(CAP_W-1){1'b0}}, cfgd});

      // Long output hold-off while samples keep coming, so the pipeline backs up.
      if (p == 2) hold_asked <= hold_asked + 1;
      if (p == 5) calm <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == 30) wait_drained();
        send_sample(pick_voltage(), pick_current(), 1'b0, '{default: '0});
      end
      if (p == 5) calm <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
